### sv/clsr_pkg.sv
package clsr_pkg;

   localparam int TABLE_SIZE   = 32;
   localparam int TABLE_AW     = $clog2(TABLE_SIZE);
   localparam int WARMUP_STEPS = 40;
   localparam int STEP_W       = $clog2(WARMUP_STEPS + 1);
   localparam int VAL_W        = 31;
   localparam int MULT_W       = 16;
   localparam int PROD_W       = VAL_W + MULT_W;
   localparam int FRAC_W       = 24;

   localparam logic [VAL_W-1:0]  M1         = 31'd2147483563;
   localparam logic [VAL_W-1:0]  M2         = 31'd2147483399;
   localparam logic [MULT_W-1:0] A1         = 16'd40014;
   localparam logic [MULT_W-1:0] A2         = 16'd40692;
   localparam logic [7:0]        FOLD1      = 8'd85;   // 2^31 mod M1
   localparam logic [7:0]        FOLD2      = 8'd249;  // 2^31 mod M2
   localparam logic [31:0]       WRAP_ADD   = 32'd2147483562;
   localparam logic [VAL_W-1:0]  RESET_GEN1 = 31'd1720212868;
   localparam logic [VAL_W-1:0]  RESET_GEN2 = 31'd1;
   localparam logic [FRAC_W-1:0] FRAC_MAX   = 24'd16777214;

   localparam logic REQ_GENERATE = 1'b0;
   localparam logic REQ_RESEED   = 1'b1;

   localparam logic [VAL_W-1:0] SEED_ONE_TABLE [TABLE_SIZE] = '{
      31'd1720212868, 31'd1392842846, 31'd1031324961, 31'd718590712,
      31'd82237802,   31'd1816996195, 31'd1529538438, 31'd1789446856,
      31'd156648835,  31'd52437849,   31'd1441478319, 31'd36906150,
      31'd1269685686, 31'd1644535938, 31'd394503142,  31'd310212663,
      31'd1596049480, 31'd7553450,    31'd322224693,  31'd445508654,
      31'd28884682,   31'd643161691,  31'd407948861,  31'd479214492,
      31'd2124954851, 31'd612891482,  31'd112933431,  31'd1814689225,
      31'd53445315,   31'd1904850491, 31'd1695805043, 31'd1860990862
   };

   typedef struct packed {
      logic gen_start;
      logic seed_start;
      logic mul_step;
      logic fold_gen;
      logic fold_seed;
      logic combine;
      logic load_out;
      logic out_seed;
   } cmd_type;

   typedef struct packed {
      logic last_step;
   } status_type;

endpackage

### sv/combined_lcg_shuffle_rng_core.sv
// Combined two-generator random number source with a 32-entry shuffle table.
// Request channel (req_): tuser selects the kind of transaction, 0 generates
// the next number, 1 reseeds from the signed 32-bit seed in tdata.
// Response channel (rsp_): one transaction per request, carrying the 31-bit
// raw value and a 24-bit 0.24 fixed-point fraction (zero after a reseed).
// A generate request multiplies both generators at the accepting clock edge,
// then reduces them, combines with the table word, and loads the value with
// its fraction. The next request can be taken once that load is done, so a
// new number is not started while the last one is still being worked.
// A reseed runs 40 steps of the first generator through the shared
// multiply-and-reduce pair, with a multiply state and a reduce state per step,
// and its response is table word 0.
// Reset loads the state for seed 1, with no clearing pass.
// While the receiver stalls the response is held; the next request is still
// accepted and worked, and waits in its final cycle until the response
// register frees.
module combined_lcg_shuffle_rng_core
   import clsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] req_type
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [30:0] raw_value, [54:31] fraction, [55] zero
);

   cmd_type           cmd;
   status_type        status;
   logic [VAL_W-1:0]  raw_value;
   logic [FRAC_W-1:0] fraction;

   clsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   clsr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .seed_value (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .raw_value  (raw_value),
      .fraction   (fraction)
   );

   assign rsp_tdata = {1'b0, fraction, raw_value};

endmodule

### sv/clsr_ctrl.sv
module clsr_ctrl
   import clsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_tuser,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GFOLD = 3'd1;
   localparam logic [2:0] S_GCOMB = 3'd2;
   localparam logic [2:0] S_RMUL  = 3'd3;
   localparam logic [2:0] S_RFOLD = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       seed_mode_ff, seed_mode_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      seed_mode_in = seed_mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.out_seed = seed_mode_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == REQ_RESEED) begin
                  cmd.seed_start = 1'b1;
                  seed_mode_in   = 1'b1;
                  state_in       = S_RMUL;
               end else begin
                  cmd.gen_start = 1'b1;
                  seed_mode_in  = 1'b0;
                  state_in      = S_GFOLD;
               end
            end
         end
         S_GFOLD: begin
            cmd.fold_gen = 1'b1;
            state_in     = S_GCOMB;
         end
         S_GCOMB: begin
            cmd.combine = 1'b1;
            state_in    = S_OUT;
         end
         S_RMUL: begin
            cmd.mul_step = 1'b1;
            state_in     = S_RFOLD;
         end
         S_RFOLD: begin
            cmd.fold_seed = 1'b1;
            state_in      = status.last_step ? S_OUT : S_RMUL;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_mode_ff <= seed_mode_in;
      end
   end

endmodule

### sv/clsr_datapath.sv
module clsr_datapath
   import clsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             seed_value,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic [VAL_W-1:0]        raw_value,
   output logic [FRAC_W-1:0]       fraction
);

   function automatic logic [VAL_W-1:0] fold_mod(input logic [PROD_W-1:0] prod,
                                                 input logic [7:0]        fold_k,
                                                 input logic [VAL_W-1:0]  modulus);
      logic [31:0] sum;
      sum = 32'(prod[VAL_W-1:0]) + 32'(prod[PROD_W-1:VAL_W]) * 32'(fold_k);
      if (sum >= 32'(modulus)) begin
         sum = sum - 32'(modulus);
      end
      return sum[VAL_W-1:0];
   endfunction

   logic [VAL_W-1:0]    x1_ff, x1_in;
   logic [VAL_W-1:0]    x2_ff, x2_in;
   logic [VAL_W-1:0]    last_ff, last_in;
   logic [VAL_W-1:0]    table_ff [TABLE_SIZE];
   logic [VAL_W-1:0]    table_in [TABLE_SIZE];
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PROD_W-1:0]   prod1_ff, prod1_in;
   logic [PROD_W-1:0]   prod2_ff, prod2_in;
   logic [TABLE_AW-1:0] slot_ff, slot_in;
   logic [VAL_W-1:0]    word_ff, word_in;
   logic [VAL_W-1:0]    raw_ff, raw_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;

   logic [31:0]         seed_abs;
   logic [VAL_W-1:0]    seed_mag;
   logic [VAL_W-1:0]    fold1;
   logic [VAL_W-1:0]    fold2;
   logic [TABLE_AW-1:0] slot_hi;
   logic [26:0]         slot_chk;
   logic [TABLE_AW-1:0] slot_pick;
   logic [31:0]         diff;
   logic [31:0]         wrapped;
   logic [31:0]         frac_chk;
   logic [FRAC_W:0]     frac_est;
   logic [FRAC_W-1:0]   frac_calc;
   logic [TABLE_AW-1:0] fill_idx;
   logic                fill_wr;

   assign seed_abs = seed_value[31] ? (32'd0 - seed_value) : seed_value;
   always_comb begin
      seed_mag = seed_abs[31] ? {VAL_W{1'b1}} : seed_abs[VAL_W-1:0];
      if (seed_mag == '0) begin
         seed_mag = VAL_W'(1);
      end
   end

   assign fold1 = fold_mod(prod1_ff, FOLD1, M1);
   assign fold2 = fold_mod(prod2_ff, FOLD2, M2);

   // slot = last / (2^26 - 2): estimate from the top bits, correct by one
   assign slot_hi   = last_ff[30:26];
   assign slot_chk  = 27'(last_ff[25:0]) + 27'({slot_hi, 1'b0}) + 27'd2;
   assign slot_pick = slot_hi + TABLE_AW'(slot_chk[26]);

   assign diff    = 32'(word_ff) - 32'(x2_ff);
   assign wrapped = (diff[31] || diff == '0) ? diff + WRAP_ADD : diff;

   // fraction = last * 2^24 / M1: estimate last >> 7, correct by one
   assign frac_chk  = {last_ff[6:0], 24'd0} +
                      32'(25'(last_ff[30:7]) + 25'd1) * 32'(FOLD1);
   assign frac_est  = 25'(last_ff[30:7]) + 25'(frac_chk[31]);
   assign frac_calc = (frac_est > 25'(FRAC_MAX)) ? FRAC_MAX : frac_est[FRAC_W-1:0];

   assign fill_idx = TABLE_AW'(step_ff - STEP_W'(1));
   assign fill_wr  = cmd.fold_seed && (step_ff <= STEP_W'(TABLE_SIZE));

   assign status.last_step = (step_ff == STEP_W'(1));

   always_comb begin
      x1_in    = x1_ff;
      x2_in    = x2_ff;
      last_in  = last_ff;
      step_in  = step_ff;
      table_in = table_ff;
      prod1_in = prod1_ff;
      prod2_in = prod2_ff;
      slot_in  = slot_ff;
      word_in  = word_ff;
      raw_in   = raw_ff;
      frac_in  = frac_ff;
      if (cmd.gen_start) begin
         prod1_in = PROD_W'(x1_ff) * PROD_W'(A1);
         prod2_in = PROD_W'(x2_ff) * PROD_W'(A2);
         slot_in  = slot_pick;
         word_in  = table_ff[slot_pick];
      end
      if (cmd.seed_start) begin
         x1_in   = seed_mag;
         x2_in   = seed_mag;
         step_in = STEP_W'(WARMUP_STEPS);
      end
      if (cmd.mul_step) begin
         prod1_in = PROD_W'(x1_ff) * PROD_W'(A1);
      end
      if (cmd.fold_gen) begin
         x1_in = fold1;
         x2_in = fold2;
      end
      if (cmd.fold_seed) begin
         x1_in   = fold1;
         step_in = step_ff - STEP_W'(1);
         if (status.last_step) begin
            last_in = fold1;
         end
      end
      if (fill_wr) begin
         table_in[fill_idx] = fold1;
      end
      if (cmd.combine) begin
         table_in[slot_ff] = x1_ff;
         last_in           = wrapped[VAL_W-1:0];
      end
      if (cmd.load_out) begin
         raw_in  = last_ff;
         frac_in = cmd.out_seed ? '0 : frac_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff   <= RESET_GEN1;
         x2_ff   <= RESET_GEN2;
         last_ff <= RESET_GEN1;
         step_ff <= '0;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            table_ff[i] <= SEED_ONE_TABLE[i];
         end
      end else begin
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         last_ff  <= last_in;
         step_ff  <= step_in;
         table_ff <= table_in;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      slot_ff  <= slot_in;
      word_ff  <= word_in;
      raw_ff   <= raw_in;
      frac_ff  <= frac_in;
   end

   assign raw_value = raw_ff;
   assign fraction  = frac_ff;

endmodule

### sv/clsr_checker.sv
module clsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[54:31] != 24'hFFFFFF)
      else $error("fraction above clamp");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response without a request in progress");

endmodule

bind combined_lcg_shuffle_rng_core clsr_checker u_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench
   import clsr_pkg::*;
();

   localparam longint Q1_TB = 53668;
   localparam longint R1_TB = 12211;
   localparam longint Q2_TB = 52774;
   localparam longint R2_TB = 3791;
   localparam longint SLOT_DIV_TB = 67108862;
   localparam int RANDOM_ITEMS = 1900;
   localparam int IDLE_PERCENT = 21;
   localparam int STALL_CYCLES = 400;
   localparam int DRAIN_CYCLES = 120;
   localparam int WATCHDOG_LIMIT = 6000;

   typedef struct packed {
      logic        kind;
      logic [31:0] seed;
   } request_type;

   typedef struct packed {
      logic [VAL_W-1:0]  raw;
      logic [FRAC_W-1:0] frac;
   } number_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;   // [0] req_type
   logic [31:0] req_tdata = '0;     // [31:0] seed_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // [30:0] raw_value, [54:31] fraction, [55] zero

   request_type request_queue[$];
   number_type  awaited_numbers[$];

   logic [VAL_W-1:0] lcg_one;
   logic [VAL_W-1:0] lcg_two;
   logic [VAL_W-1:0] last_number;
   logic [VAL_W-1:0] shuffle_words [TABLE_SIZE];

   int errors = 0;
   int cycle_count = 0;
   int generates_sent = 0;
   int reseeds_sent = 0;
   int numbers_checked = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;
   int idle_cycles = 0;

   combined_lcg_shuffle_rng_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [VAL_W-1:0] schrage_step(logic [VAL_W-1:0] x, longint a,
                                                      longint q, longint r, longint m);
      longint xv;
      longint k;
      longint v;
      xv = longint'(x);
      k = xv / q;
      v = (xv - k * q) * a - k * r;
      if (v < 0) v = v + m;
      return v[VAL_W-1:0];
   endfunction

   function automatic number_type next_number(logic kind, logic [31:0] seed);
      number_type  n;
      logic [31:0] mag;
      int          slot;
      longint      v;
      longint      frac;
      if (kind == REQ_RESEED) begin
         mag = seed[31] ? (32'd0 - seed) : seed;
         if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
         if (mag == 32'd0) mag = 32'd1;
         lcg_one = mag[VAL_W-1:0];
         lcg_two = mag[VAL_W-1:0];
         for (int j = WARMUP_STEPS; j >= 1; j--) begin
            lcg_one = schrage_step(lcg_one, longint'(A1), Q1_TB, R1_TB, longint'(M1));
            if (j <= TABLE_SIZE) shuffle_words[j-1] = lcg_one;
         end
         last_number = shuffle_words[0];
         n.raw = last_number;
         n.frac = '0;
      end else begin
         lcg_one = schrage_step(lcg_one, longint'(A1), Q1_TB, R1_TB, longint'(M1));
         lcg_two = schrage_step(lcg_two, longint'(A2), Q2_TB, R2_TB, longint'(M2));
         slot = int'((longint'(last_number) / SLOT_DIV_TB) % TABLE_SIZE);
         v = longint'(shuffle_words[slot]) - longint'(lcg_two);
         shuffle_words[slot] = lcg_one;
         if (v < 1) v = v + longint'(WRAP_ADD);
         last_number = v[VAL_W-1:0];
         frac = (longint'(last_number) << FRAC_W) / longint'(M1);
         if (frac > longint'(FRAC_MAX)) frac = longint'(FRAC_MAX);
         n.raw = last_number;
         n.frac = frac[FRAC_W-1:0];
      end
      return n;
   endfunction

   function automatic bit quiet_window();
      return cycle_count >= 3000 && cycle_count < 4500;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // driver: predict on each accepted request, then offer the next one
   always @(posedge clock) begin
      request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         lcg_one = RESET_GEN1;
         lcg_two = RESET_GEN2;
         last_number = RESET_GEN1;
         for (int i = 0; i < TABLE_SIZE; i++) shuffle_words[i] = SEED_ONE_TABLE[i];
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_numbers.push_back(next_number(req_tuser, req_tdata));
            if (req_tuser == REQ_RESEED) reseeds_sent++;
            else generates_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_queue.size() > 0 &&
                (quiet_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
               item = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item.kind;
               req_tdata <= item.seed;
            end else begin
               req_tvalid <= 1'b0;
               req_tdata <= $urandom;
            end
         end
      end
   end

   // monitor: check each response transaction against the oldest prediction
   always @(posedge clock) begin
      number_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_numbers.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = awaited_numbers.pop_front();
               numbers_checked++;
               if (rsp_tdata[30:0] !== want.raw) begin
                  $display("%0t: raw_value expected %0d actual %0d",
                           $time, want.raw, rsp_tdata[30:0]);
                  errors++;
               end
               if (rsp_tdata[54:31] !== want.frac) begin
                  $display("%0t: fraction expected %0d actual %0d",
                           $time, want.frac, rsp_tdata[54:31]);
                  errors++;
               end
               if (rsp_tdata[55] !== 1'b0) begin
                  $display("%0t: pad bit expected 0 actual %b", $time, rsp_tdata[55]);
                  errors++;
               end
            end
         end
         if (!stall_done && numbers_checked == 300) begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_window() || $urandom_range(99) >= IDLE_PERCENT;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("combined_lcg_shuffle_rng_core regression: fail");
            $finish;
         end
      end
   end

   task automatic push_request(logic kind, logic [31:0] seed);
      request_type item;
      item.kind = kind;
      item.seed = seed;
      request_queue.push_back(item);
   endtask

   task automatic wait_for_drain();
      while (request_queue.size() > 0 || req_tvalid || awaited_numbers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] odd_seeds [8];
      int pick;
      odd_seeds = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0001, 32'd2147483563, 32'd2147483399};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: state after reset, special seeds, each followed by generates
      repeat (3) push_request(REQ_GENERATE, $urandom);
      push_request(REQ_RESEED, 32'd0);
      repeat (2) push_request(REQ_GENERATE, 32'hFFFF_FFFF);
      push_request(REQ_RESEED, 32'd1);
      push_request(REQ_GENERATE, 32'd0);
      push_request(REQ_RESEED, 32'hFFFF_FFFF);
      push_request(REQ_GENERATE, $urandom);
      push_request(REQ_RESEED, 32'h7FFF_FFFF);
      push_request(REQ_GENERATE, $urandom);
      push_request(REQ_RESEED, 32'h8000_0000);
      push_request(REQ_GENERATE, $urandom);
      push_request(REQ_RESEED, 32'h8000_0001);
      push_request(REQ_GENERATE, $urandom);
      push_request(REQ_RESEED, 32'd2147483563);
      repeat (2) push_request(REQ_GENERATE, $urandom);
      push_request(REQ_RESEED, 32'd2147483399);
      push_request(REQ_GENERATE, $urandom);
      push_request(REQ_RESEED, 32'd2147483562);
      push_request(REQ_GENERATE, $urandom);
      wait_for_drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 4) push_request(REQ_RESEED, $urandom);
         else if (pick == 4) push_request(REQ_RESEED, odd_seeds[$urandom_range(7)]);
         else push_request(REQ_GENERATE, $urandom);
      end
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d generate and %0d reseed requests, %0d responses checked",
               generates_sent, reseeds_sent, numbers_checked);
      $display("including special seeds, a long receiver stall and mid-run drains");
      if (errors == 0 && awaited_numbers.size() == 0) begin
         $display("combined_lcg_shuffle_rng_core regression: pass");
      end else begin
         $display("combined_lcg_shuffle_rng_core regression: fail");
      end
      $finish;
   end

endmodule

### files.f
sv/clsr_pkg.sv
sv/clsr_ctrl.sv
sv/clsr_datapath.sv
sv/combined_lcg_shuffle_rng_core.sv
sv/clsr_checker.sv
tb/testbench.sv
